### design/ktt_pkg.sv
// Shared types for the key/value text tokenizer: result events, one result
// transfer and the burst of results that one input item causes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ktt_pkg;

    // Most results that one input item can cause.
    localparam int RES_MAX = 3;

    typedef enum logic [2:0] {
        EV_CHAR  = 3'd0,
        EV_SEND  = 3'd1,
        EV_OPEN  = 3'd2,
        EV_CLOSE = 3'd3,
        EV_EOI   = 3'd4
    } t_event;

    typedef struct packed {
        t_event     ev;
        logic [7:0] ch;
        logic       last;
    } t_result;

    typedef struct packed {
        logic [1:0]                 cnt;
        t_result [RES_MAX-1:0]      res;
    } t_burst;

endpackage

`default_nettype wire

### design/ktt_lexer.sv
// Lexer mode register and the decode of one held input item into a burst of
// up to three results. Depends on ktt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ktt_lexer (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_advance,   // item consumed this cycle
    input  wire logic            i_kind,
    input  wire logic [7:0]      i_byte,
    output ktt_pkg::t_burst      o_burst
);

    typedef enum logic [5:0] {
        M_BETWEEN = 6'b000001,
        M_SLASH   = 6'b000010,
        M_COMMENT = 6'b000100,
        M_QUOTED  = 6'b001000,
        M_ESCAPE  = 6'b010000,
        M_BARE    = 6'b100000
    } t_mode;

    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    t_mode r_mode;
    t_mode n_mode;

    ktt_pkg::t_result bw0;
    ktt_pkg::t_result bw1;
    logic [1:0]       bw_n;
    t_mode            bw_mode;

    ktt_pkg::t_result [ktt_pkg::RES_MAX-1:0] res;
    logic [1:0]                              cnt;

    function automatic logic is_ws(input logic [7:0] b);
        return (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);
    endfunction

    function automatic ktt_pkg::t_result mk(input ktt_pkg::t_event ev,
                                            input logic [7:0] ch);
        ktt_pkg::t_result r;
        r.ev   = ev;
        r.ch   = (ev == ktt_pkg::EV_CHAR) ? ch : 8'h00;
        r.last = 1'b0;
        return r;
    endfunction

    // One byte inside or starting a bare word
    always_comb begin
        bw1 = mk(ktt_pkg::EV_CHAR, 8'h00);
        if (is_ws(i_byte)) begin
            bw0     = mk(ktt_pkg::EV_SEND, 8'h00);
            bw_n    = 2'd1;
            bw_mode = M_BETWEEN;
        end else if (i_byte == CH_LBRACE) begin
            bw0     = mk(ktt_pkg::EV_SEND, 8'h00);
            bw1     = mk(ktt_pkg::EV_OPEN, 8'h00);
            bw_n    = 2'd2;
            bw_mode = M_BETWEEN;
        end else if (i_byte == CH_RBRACE) begin
            bw0     = mk(ktt_pkg::EV_SEND, 8'h00);
            bw1     = mk(ktt_pkg::EV_CLOSE, 8'h00);
            bw_n    = 2'd2;
            bw_mode = M_BETWEEN;
        end else begin
            bw0     = mk(ktt_pkg::EV_CHAR, i_byte);
            bw_n    = 2'd1;
            bw_mode = M_BARE;
        end
    end

    always_comb begin
        res    = '0;
        cnt    = 2'd0;
        n_mode = r_mode;
        if (i_kind) begin
            n_mode = M_BETWEEN;
            unique case (r_mode)
                M_SLASH: begin
                    res[0] = mk(ktt_pkg::EV_CHAR, CH_SLASH);
                    res[1] = mk(ktt_pkg::EV_SEND, 8'h00);
                    res[2] = mk(ktt_pkg::EV_EOI, 8'h00);
                    cnt    = 2'd3;
                end
                M_ESCAPE: begin
                    res[0] = mk(ktt_pkg::EV_CHAR, CH_BSLASH);
                    res[1] = mk(ktt_pkg::EV_SEND, 8'h00);
                    res[2] = mk(ktt_pkg::EV_EOI, 8'h00);
                    cnt    = 2'd3;
                end
                M_QUOTED, M_BARE: begin
                    res[0] = mk(ktt_pkg::EV_SEND, 8'h00);
                    res[1] = mk(ktt_pkg::EV_EOI, 8'h00);
                    cnt    = 2'd2;
                end
                default: begin
                    res[0] = mk(ktt_pkg::EV_EOI, 8'h00);
                    cnt    = 2'd1;
                end
            endcase
        end else begin
            unique case (r_mode)
                M_SLASH: begin
                    if (i_byte == CH_SLASH) begin
                        n_mode = M_COMMENT;
                    end else begin
                        res[0] = mk(ktt_pkg::EV_CHAR, CH_SLASH);
                        res[1] = bw0;
                        res[2] = bw1;
                        cnt    = bw_n + 2'd1;
                        n_mode = bw_mode;
                    end
                end
                M_COMMENT: begin
                    if (i_byte == CH_LF) begin
                        n_mode = M_BETWEEN;
                    end
                end
                M_QUOTED: begin
                    if (i_byte == CH_QUOTE) begin
                        res[0] = mk(ktt_pkg::EV_SEND, 8'h00);
                        cnt    = 2'd1;
                        n_mode = M_BETWEEN;
                    end else if (i_byte == CH_BSLASH) begin
                        n_mode = M_ESCAPE;
                    end else begin
                        res[0] = mk(ktt_pkg::EV_CHAR, i_byte);
                        cnt    = 2'd1;
                    end
                end
                M_ESCAPE: begin
                    priority if (i_byte == CH_N) begin
                        res[0] = mk(ktt_pkg::EV_CHAR, CH_LF);
                    end else if (i_byte == CH_T) begin
                        res[0] = mk(ktt_pkg::EV_CHAR, CH_TAB);
                    end else if (i_byte == CH_R) begin
                        res[0] = mk(ktt_pkg::EV_CHAR, CH_CR);
                    end else begin
                        res[0] = mk(ktt_pkg::EV_CHAR, i_byte);
                    end
                    cnt    = 2'd1;
                    n_mode = M_QUOTED;
                end
                M_BARE: begin
                    res[0] = bw0;
                    res[1] = bw1;
                    cnt    = bw_n;
                    n_mode = bw_mode;
                end
                default: begin
                    // between tokens; unreachable codes land here as well
                    n_mode = M_BETWEEN;
                    priority if (is_ws(i_byte)) begin
                        n_mode = M_BETWEEN;
                    end else if (i_byte == CH_LBRACE) begin
                        res[0] = mk(ktt_pkg::EV_OPEN, 8'h00);
                        cnt    = 2'd1;
                    end else if (i_byte == CH_RBRACE) begin
                        res[0] = mk(ktt_pkg::EV_CLOSE, 8'h00);
                        cnt    = 2'd1;
                    end else if (i_byte == CH_QUOTE) begin
                        n_mode = M_QUOTED;
                    end else if (i_byte == CH_SLASH) begin
                        n_mode = M_SLASH;
                    end else begin
                        res[0] = mk(ktt_pkg::EV_CHAR, i_byte);
                        cnt    = 2'd1;
                        n_mode = M_BARE;
                    end
                end
            endcase
        end

        // mark the final result of this item
        unique case (cnt)
            2'd1:    res[0].last = 1'b1;
            2'd2:    res[1].last = 1'b1;
            2'd3:    res[2].last = 1'b1;
            default: res[0].last = res[0].last;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_BETWEEN;
        end else if (i_advance) begin
            r_mode <= n_mode;
        end
    end

    assign o_burst.cnt = cnt;
    assign o_burst.res = res;

endmodule

`default_nettype wire

### design/ktt_burst.sv
// Result register: holds the burst of one item and hands it out one transfer
// per cycle on the output stream while i_take_ready is high. Depends on ktt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ktt_burst (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_load,
    input  wire ktt_pkg::t_burst i_burst,
    input  wire logic            i_take_ready,
    output logic                 o_valid,
    output ktt_pkg::t_result     o_result,
    output logic                 o_free
);

    ktt_pkg::t_result [ktt_pkg::RES_MAX-1:0] r_res;
    logic [1:0]                              r_cnt;
    logic [1:0]                              r_idx;

    logic at_end;

    assign o_valid  = (r_cnt != 2'd0);
    assign o_result = r_res[r_idx];
    assign at_end   = (r_idx == r_cnt - 2'd1);
    // free once empty, or when the final entry leaves this cycle
    assign o_free   = !o_valid || (i_take_ready && at_end);

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_burst.res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_idx <= 2'd0;
        end else if (i_load) begin
            r_cnt <= i_burst.cnt;
            r_idx <= 2'd0;
        end else if (o_valid && i_take_ready) begin
            if (at_end) begin
                r_cnt <= 2'd0;
                r_idx <= 2'd0;
            end else begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

### design/keyvalue_text_tokenizer_unit.sv
// Top level of the key/value text tokenizer: input register, lexer and result
// register. Depends on ktt_pkg, ktt_lexer and ktt_burst.
`timescale 1ns / 1ps
`default_nettype none

// Streaming lexer for brace-structured key/value text. Feed the document one
// byte per transfer on the slave side (tuser = 0), then one end-of-document
// transfer (tuser = 1, data ignored). The master side emits lexical events:
// string characters (escapes n, t, r translated), string end, open brace,
// close brace and end of input; tlast marks the final event caused by one
// input transfer. After end of input the lexer is back between tokens and
// the next byte starts a fresh document. Each byte waits in the input register
// until its burst fits in the result register and is decoded into a burst of up
// to three events; the result register then drains that burst at one event per
// cycle while the master side is ready. The block takes one byte per cycle while
// each byte yields at most one event and the master side is ready; a byte
// yielding more events holds the next byte in the input register until its
// burst has drained. Bytes that yield no event (comment text, opening quotes,
// escape backslashes) pass without waiting for the result register.
module keyvalue_text_tokenizer_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  wire logic [0:0]  s_axis_tuser,   // [0] kind
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // [7:0] char_value
    output logic [2:0]       m_axis_tuser,   // [2:0] event_res
    output logic             m_axis_tlast
);

    logic       r_in_valid;
    logic       r_kind;
    logic [7:0] r_byte;

    ktt_pkg::t_burst  burst;
    ktt_pkg::t_result result;
    logic             advance;
    logic             out_free;

    // Consume the held item when its burst fits in the result register;
    // items with no events never wait.
    assign advance       = r_in_valid && ((burst.cnt == 2'd0) || out_free);
    assign s_axis_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    // hold payload until the next accepted transfer
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_kind <= s_axis_tuser[0];
            r_byte <= s_axis_tdata;
        end
    end

    ktt_lexer u_lexer (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_kind    (r_kind),
        .i_byte    (r_byte),
        .o_burst   (burst)
    );

    ktt_burst u_burst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (advance && (burst.cnt != 2'd0)),
        .i_burst      (burst),
        .i_take_ready (m_axis_tready),
        .o_valid      (m_axis_tvalid),
        .o_result     (result),
        .o_free       (out_free)
    );

    assign m_axis_tuser = result.ev;
    assign m_axis_tdata = result.ch;
    assign m_axis_tlast = result.last;

endmodule

`default_nettype wire

### verif/tb_top.sv
// Self-checking bench for keyvalue_text_tokenizer_unit: directed table, then random documents.
// Depends on ktt_pkg (event codes, result struct) and the tokenizer top level.
`timescale 1ns / 1ps

module tb_top;
    import ktt_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 480;
    localparam int DRAIN_CYCLES = 8;
    localparam int STALL_PCT    = 18;

    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_END  = 1'b1;

    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_R      = 8'h72;

    typedef enum logic [2:0] {
        LX_BETWEEN = 3'd0,
        LX_SLASH   = 3'd1,
        LX_COMMENT = 3'd2,
        LX_QUOTED  = 3'd3,
        LX_ESCAPE  = 3'd4,
        LX_BARE    = 3'd5
    } t_lex_mode;

    // One directed transfer. n_res < 0 means the predictor supplies the events;
    // otherwise the first n_res (event, char) pairs are the typed-in answer.
    typedef struct packed {
        logic       kind;
        logic [7:0] data;
        int         n_res;
        t_event     ev0;
        logic [7:0] ch0;
        t_event     ev1;
        logic [7:0] ch1;
        t_event     ev2;
        logic [7:0] ch2;
    } t_lex_row;

    localparam int DIRECTED_N = 26;
    localparam t_lex_row DIRECTED [DIRECTED_N] = '{
        // right after reset: NUL opens a bare word
        '{KIND_BYTE, 8'h00, 1, EV_CHAR, 8'h00, EV_CHAR, 8'h00, EV_CHAR, 8'h00},
        // brace closes the word
        '{KIND_BYTE, CH_LBRACE, 2, EV_SEND, 8'h00, EV_OPEN, 8'h00, EV_CHAR, 8'h00},
        '{KIND_BYTE, CH_RBRACE, -1, EV_CHAR, 8'h00, EV_CHAR, 8'h00, EV_CHAR, 8'h00},
        // quoted string with n, t, r escapes and a raw 0xFF escape
        '{KIND_BYTE, CH_QUOTE, -1, EV_CHAR, 8'h00, EV_CHAR, 8'h00, EV_CHAR, 8'h00},
        '{KIND_BYTE, CH_BSLASH, -1, EV_CHAR, 8'h00, EV_CHAR, 8'h00, EV_CHAR, 8'h00},
        '{KIND_BYTE, CH_N, -1, EV_CHAR, 8'h00, EV_CHAR, 8'h00, EV_CHAR, 8'h00},
        '{KIND_BYTE, CH_BSLASH, -1, EV_CHAR, 8'h00, EV_CHAR, 8'h00, EV_CHAR, 8'h00},
        '{KIND_BYTE, CH_T, -1, EV_CHAR, 8'h00, EV_CHAR, 8'h00, EV_CHAR, 8'h00},
        '{KIND_BYTE, CH_BSLASH, -1, EV_CHAR, 8'h00, EV_CHAR, 8'h00, EV_CHAR, 8'h00},
        '{KIND_BYTE, CH_R, -1, EV_CHAR, 8'h00, EV_CHAR, 8'h00, EV_CHAR, 8'h00},
        '{KIND_BYTE, CH_BSLASH, -1, EV_CHAR, 8'h00, EV_CHAR, 8'h00, EV_CHAR, 8'h00},
        '{KIND_BYTE, 8'hFF, 1, EV_CHAR, 8'hFF, EV_CHAR, 8'h00, EV_CHAR, 8'h00},
        // unterminated string at end of document, data field all ones
        '{KIND_END, 8'hFF, 2, EV_SEND, 8'h00, EV_EOI, 8'h00, EV_CHAR, 8'h00},
        // lone slash starts a word; slashes and a quote inside stay text
        '{KIND_BYTE, CH_SLASH, -1, EV_CHAR, 8'h00, EV_CHAR, 8'h00, EV_CHAR, 8'h00},
        '{KIND_BYTE, 8'h61, -1, EV_CHAR, 8'h00, EV_CHAR, 8'h00, EV_CHAR, 8'h00},
        '{KIND_BYTE, CH_SLASH, -1, EV_CHAR, 8'h00, EV_CHAR, 8'h00, EV_CHAR, 8'h00},
        '{KIND_BYTE, CH_SLASH, -1, EV_CHAR, 8'h00, EV_CHAR, 8'h00, EV_CHAR, 8'h00},
        '{KIND_BYTE, CH_QUOTE, -1, EV_CHAR, 8'h00, EV_CHAR, 8'h00, EV_CHAR, 8'h00},
        '{KIND_BYTE, CH_TAB, -1, EV_CHAR, 8'h00, EV_CHAR, 8'h00, EV_CHAR, 8'h00},
        // held slash released by a close brace: three events from one byte
        '{KIND_BYTE, CH_SLASH, -1, EV_CHAR, 8'h00, EV_CHAR, 8'h00, EV_CHAR, 8'h00},
        '{KIND_BYTE, CH_RBRACE, -1, EV_CHAR, 8'h00, EV_CHAR, 8'h00, EV_CHAR, 8'h00},
        // trailing backslash inside a string
        '{KIND_BYTE, CH_QUOTE, -1, EV_CHAR, 8'h00, EV_CHAR, 8'h00, EV_CHAR, 8'h00},
        '{KIND_BYTE, CH_BSLASH, -1, EV_CHAR, 8'h00, EV_CHAR, 8'h00, EV_CHAR, 8'h00},
        '{KIND_END, 8'h00, 3, EV_CHAR, CH_BSLASH, EV_SEND, 8'h00, EV_EOI, 8'h00},
        // held slash at end of document
        '{KIND_BYTE, CH_SLASH, -1, EV_CHAR, 8'h00, EV_CHAR, 8'h00, EV_CHAR, 8'h00},
        '{KIND_END, 8'h00, 3, EV_CHAR, CH_SLASH, EV_SEND, 8'h00, EV_EOI, 8'h00}
    };

    logic       i_clk;
    logic       i_rst_n       = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata  = 8'h00;   // [7:0] data_byte
    logic [0:0] s_axis_tuser  = 1'b0;    // [0] kind
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;            // [7:0] char_value
    logic [2:0] m_axis_tuser;            // [2:0] event_res
    logic       m_axis_tlast;

    keyvalue_text_tokenizer_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // 12 ns period
    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    t_lex_mode lex_mode = LX_BETWEEN;   // predictor's copy of the lexer mode
    t_result   lex_out[$];              // events the last input item causes
    t_result   typed_burst[$];          // typed-in answer for a directed row
    t_result   pending_events[$];       // expected events not yet seen

    bit calm         = 1'b0;            // suspend idling on both sides
    int errors       = 0;
    int items_sent   = 0;
    int docs_sent    = 0;
    int events_seen  = 0;
    int cycle_count  = 0;

    // ---------------------------------------------------------------------
    // Event predictor
    // ---------------------------------------------------------------------
    function automatic bit is_space(logic [7:0] b);
        return b == CH_SPACE || (b >= CH_TAB && b <= CH_CR);
    endfunction

    function automatic void emit(t_event ev, logic [7:0] ch);
        t_result r;
        r.ev   = ev;
        r.ch   = (ev == EV_CHAR) ? ch : 8'h00;
        r.last = 1'b0;
        lex_out.push_back(r);
    endfunction

    // Byte that continues (or starts) a bare word.
    function automatic void word_byte(logic [7:0] b);
        if (is_space(b)) begin
            emit(EV_SEND, 8'h00);
            lex_mode = LX_BETWEEN;
        end else if (b == CH_LBRACE) begin
            emit(EV_SEND, 8'h00);
            emit(EV_OPEN, 8'h00);
            lex_mode = LX_BETWEEN;
        end else if (b == CH_RBRACE) begin
            emit(EV_SEND, 8'h00);
            emit(EV_CLOSE, 8'h00);
            lex_mode = LX_BETWEEN;
        end else begin
            emit(EV_CHAR, b);
            lex_mode = LX_BARE;
        end
    endfunction

    function automatic void lex_step(logic kind, logic [7:0] b);
        lex_out.delete();
        if (kind == KIND_END) begin
            // flush whatever token is open, then end of input
            case (lex_mode)
                LX_SLASH: begin
                    emit(EV_CHAR, CH_SLASH);
                    emit(EV_SEND, 8'h00);
                end
                LX_ESCAPE: begin
                    emit(EV_CHAR, CH_BSLASH);
                    emit(EV_SEND, 8'h00);
                end
                LX_QUOTED, LX_BARE: begin
                    emit(EV_SEND, 8'h00);
                end
                default: ;
            endcase
            emit(EV_EOI, 8'h00);
            lex_mode = LX_BETWEEN;
        end else begin
            case (lex_mode)
                LX_SLASH: begin
                    if (b == CH_SLASH) begin
                        lex_mode = LX_COMMENT;
                    end else begin
                        emit(EV_CHAR, CH_SLASH);
                        word_byte(b);
                    end
                end
                LX_COMMENT: begin
                    if (b == CH_LF) lex_mode = LX_BETWEEN;
                end
                LX_QUOTED: begin
                    if (b == CH_QUOTE) begin
                        emit(EV_SEND, 8'h00);
                        lex_mode = LX_BETWEEN;
                    end else if (b == CH_BSLASH) begin
                        lex_mode = LX_ESCAPE;
                    end else begin
                        emit(EV_CHAR, b);
                    end
                end
                LX_ESCAPE: begin
                    if (b == CH_N)      emit(EV_CHAR, CH_LF);
                    else if (b == CH_T) emit(EV_CHAR, CH_TAB);
                    else if (b == CH_R) emit(EV_CHAR, CH_CR);
                    else                emit(EV_CHAR, b);
                    lex_mode = LX_QUOTED;
                end
                LX_BARE: begin
                    word_byte(b);
                end
                default: begin
                    lex_mode = LX_BETWEEN;
                    if (is_space(b)) begin
                        // skip
                    end else if (b == CH_LBRACE) begin
                        emit(EV_OPEN, 8'h00);
                    end else if (b == CH_RBRACE) begin
                        emit(EV_CLOSE, 8'h00);
                    end else if (b == CH_QUOTE) begin
                        lex_mode = LX_QUOTED;
                    end else if (b == CH_SLASH) begin
                        lex_mode = LX_SLASH;
                    end else begin
                        emit(EV_CHAR, b);
                        lex_mode = LX_BARE;
                    end
                end
            endcase
        end
        if (lex_out.size() > 0) lex_out[lex_out.size() - 1].last = 1'b1;
    endfunction

    // ---------------------------------------------------------------------
    // Input side: drive at the falling edge, hold until the transfer
    // ---------------------------------------------------------------------
    task automatic send_item(input logic kind, input logic [7:0] data, input bit typed);
        while (!calm && $urandom_range(99) < STALL_PCT) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= data;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        // transfer taken at this edge: queue what it should cause
        lex_step(kind, data);
        if (typed) begin
            foreach (typed_burst[k]) pending_events.push_back(typed_burst[k]);
        end else begin
            foreach (lex_out[k]) pending_events.push_back(lex_out[k]);
        end
        items_sent++;
        @(negedge i_clk);
    endtask

    function automatic logic [7:0] space_char();
        int idx;
        idx = $urandom_range(0, 5);
        return (idx == 5) ? CH_SPACE : CH_TAB + 8'(idx);
    endfunction

    // Any byte that keeps a bare word going.
    function automatic logic [7:0] word_char();
        logic [7:0] b;
        do b = 8'($urandom_range(255));
        while (is_space(b) || b == CH_LBRACE || b == CH_RBRACE);
        return b;
    endfunction

    function automatic logic [7:0] quoted_char();
        logic [7:0] b;
        do b = 8'($urandom_range(255));
        while (b == CH_QUOTE || b == CH_BSLASH);
        return b;
    endfunction

    // One document: a handful of tokens with random content, then end of data.
    // Mostly well-formed; a few strings stay open and some raw noise is mixed in.
    task automatic send_document();
        int n_tok;
        int len;
        logic [7:0] b;
        n_tok = $urandom_range(1, 8);
        repeat (n_tok) begin
            case ($urandom_range(0, 9))
                0, 1: send_item(KIND_BYTE, space_char(), 1'b0);
                2:    send_item(KIND_BYTE, CH_LBRACE, 1'b0);
                3:    send_item(KIND_BYTE, CH_RBRACE, 1'b0);
                4, 5: begin
                    send_item(KIND_BYTE, CH_QUOTE, 1'b0);
                    len = $urandom_range(0, 6);
                    repeat (len) begin
                        if ($urandom_range(0, 4) == 0) begin
                            send_item(KIND_BYTE, CH_BSLASH, 1'b0);
                            case ($urandom_range(0, 5))
                                0:       b = CH_N;
                                1:       b = CH_T;
                                2:       b = CH_R;
                                3:       b = CH_QUOTE;
                                4:       b = CH_BSLASH;
                                default: b = 8'($urandom_range(255));
                            endcase
                            send_item(KIND_BYTE, b, 1'b0);
                        end else begin
                            send_item(KIND_BYTE, quoted_char(), 1'b0);
                        end
                    end
                    if ($urandom_range(0, 9) != 0) send_item(KIND_BYTE, CH_QUOTE, 1'b0);
                end
                6: begin
                    // first byte must not open a string or a held slash
                    do b = word_char();
                    while (b == CH_QUOTE || b == CH_SLASH);
                    send_item(KIND_BYTE, b, 1'b0);
                    len = $urandom_range(0, 5);
                    repeat (len) send_item(KIND_BYTE, word_char(), 1'b0);
                    case ($urandom_range(0, 3))
                        0:       send_item(KIND_BYTE, CH_LBRACE, 1'b0);
                        1:       send_item(KIND_BYTE, CH_RBRACE, 1'b0);
                        default: send_item(KIND_BYTE, space_char(), 1'b0);
                    endcase
                end
                7: begin
                    send_item(KIND_BYTE, CH_SLASH, 1'b0);
                    send_item(KIND_BYTE, CH_SLASH, 1'b0);
                    len = $urandom_range(0, 5);
                    repeat (len) begin
                        do b = 8'($urandom_range(255));
                        while (b == CH_LF);
                        send_item(KIND_BYTE, b, 1'b0);
                    end
                    send_item(KIND_BYTE, CH_LF, 1'b0);
                end
                8: begin
                    send_item(KIND_BYTE, CH_SLASH, 1'b0);
                    do b = 8'($urandom_range(255));
                    while (b == CH_SLASH);
                    send_item(KIND_BYTE, b, 1'b0);
                end
                default: begin
                    len = $urandom_range(1, 4);
                    repeat (len) send_item(KIND_BYTE, 8'($urandom_range(255)), 1'b0);
                end
            endcase
        end
        send_item(KIND_END, 8'($urandom_range(255)), 1'b0);
        docs_sent++;
    endtask

    // ---------------------------------------------------------------------
    // Output side: random back-pressure, check each transfer in order
    // ---------------------------------------------------------------------
    always @(negedge i_clk) begin
        m_axis_tready <= calm || ($urandom_range(99) >= STALL_PCT);
    end

    always @(posedge i_clk) begin : check_events
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            events_seen++;
            if (pending_events.size() == 0) begin
                $error("unexpected event: event_res %0d char_value %02h last %0b",
                       m_axis_tuser, m_axis_tdata, m_axis_tlast);
                errors++;
            end else begin
                want = pending_events.pop_front();
                if (m_axis_tuser != want.ev) begin
                    $error("event_res: expected %0d, got %0d", want.ev, m_axis_tuser);
                    errors++;
                end
                if (m_axis_tdata != want.ch) begin
                    $error("char_value: expected %02h, got %02h", want.ch, m_axis_tdata);
                    errors++;
                end
                if (m_axis_tlast != want.last) begin
                    $error("last: expected %0b, got %0b", want.last, m_axis_tlast);
                    errors++;
                end
            end
        end
    end

    // Hard stop if the block hangs.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d events outstanding",
                     cycle_count, pending_events.size());
            $display("tb_top: done, errors");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------------
    initial begin : main_seq
        t_result r;
        t_lex_row row;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        for (int i = 0; i < DIRECTED_N; i++) begin
            row = DIRECTED[i];
            typed_burst.delete();
            for (int k = 0; k < row.n_res; k++) begin
                r.ev   = (k == 0) ? row.ev0 : (k == 1) ? row.ev1 : row.ev2;
                r.ch   = (k == 0) ? row.ch0 : (k == 1) ? row.ch1 : row.ch2;
                r.last = (k == row.n_res - 1);
                typed_burst.push_back(r);
            end
            send_item(row.kind, row.data, row.n_res >= 0);
        end

        // random documents; one stretch runs with no idling on either side
        while (items_sent < DIRECTED_N + RANDOM_ITEMS) begin
            calm = (items_sent >= DIRECTED_N + 200) && (items_sent < DIRECTED_N + 320);
            send_document();
        end
        calm = 1'b0;
        s_axis_tvalid <= 1'b0;

        while (pending_events.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d input transfers in %0d random documents plus a directed table,",
                 items_sent, docs_sent);
        $display("%0d events checked in %0d cycles", events_seen, cycle_count);
        if (errors == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule

### sim.f
design/ktt_pkg.sv
design/ktt_lexer.sv
design/ktt_burst.sv
design/keyvalue_text_tokenizer_unit.sv
verif/tb_top.sv
